[hdl/usm3_pkg.sv]
// ----------------------------------------------------------------------------
// usm3_pkg
// Shared constants and types for the 3x3 rgb unsharp mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package usm3_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = 11;   // column position
  localparam int ROW_W    = 12;   // row position
  localparam int WIDTH_W  = 12;   // image_width register
  localparam int HEIGHT_W = 13;   // image_height register
  localparam int GAIN_W   = 3;    // detail_gain register
  localparam int CH_W     = 8;    // one color channel
  localparam int PIX_W    = 3 * CH_W;
  localparam int SUM_W    = 12;   // sum of nine channel values

  // floor(x / 9) == (x * RECIP_9) >> RECIP_SHIFT for every x below 2**15
  localparam int RECIP_9     = 3641;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = 24;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN   = 2'd2;

  // stage load enables for a channel datapath
  typedef struct packed {
    logic ld_sum;
    logic ld_detail;
    logic ld_out;
  } chan_ctl_t;

endpackage

`default_nettype wire

[hdl/usm3_chan.sv]
// ----------------------------------------------------------------------------
// usm3_chan
// One color channel of the sharpening datapath: 3x3 sum, divide by nine,
// detail extraction and saturating add-back, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module usm3_chan (
  input  wire logic                                     clk,
  input  wire usm3_pkg::chan_ctl_t                      ctl,
  input  wire logic [8:0][usm3_pkg::CH_W-1:0]           nbr,    // row-major 3x3
  input  wire logic [usm3_pkg::GAIN_W-1:0]              gain,
  output logic      [usm3_pkg::CH_W-1:0]                pix_out
);

  logic [usm3_pkg::SUM_W-1:0]  sum9;
  logic [usm3_pkg::SUM_W-1:0]  sum_q;
  logic [usm3_pkg::CH_W-1:0]   ctr_s2;
  logic [usm3_pkg::PROD_W-1:0] prod;
  logic [usm3_pkg::CH_W-1:0]   blur;
  logic [usm3_pkg::CH_W-1:0]   detail_q;
  logic [usm3_pkg::CH_W-1:0]   ctr_s3;
  logic [10:0]                 sharp;

  // neighborhood sum
  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 9; k++) begin
      sum9 = sum9 + usm3_pkg::SUM_W'(nbr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum_q  <= sum9;
      ctr_s2 <= nbr[4];
    end
  end

  // blur by reciprocal multiply, then clipped detail
  assign prod = usm3_pkg::PROD_W'(sum_q) * usm3_pkg::PROD_W'(usm3_pkg::RECIP_9);
  assign blur = prod[usm3_pkg::RECIP_SHIFT +: usm3_pkg::CH_W];

  always_ff @(posedge clk) begin
    if (ctl.ld_detail) begin
      detail_q <= (ctr_s2 > blur) ? (ctr_s2 - blur) : '0;
      ctr_s3   <= ctr_s2;
    end
  end

  // add scaled detail back, saturate at full scale
  assign sharp = 11'(ctr_s3) + 11'(gain) * 11'(detail_q);

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      pix_out <= (sharp > 11'd255) ? 8'd255 : sharp[usm3_pkg::CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/unsharp_mask_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// unsharp_mask_3x3_rgb
// 3x3 box-blur unsharp mask on a raster-order rgb pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and gives one
// sharpened pixel for every interior position; border pixels are consumed
// without a result and frames narrower or shorter than 3 give none. A result
// goes through line store read, sum, divide and detail, and final add. The
// two previous rows live in one 2048 x 48 line memory, read once and
// written once per pixel at its column, which sets the rate at one pixel
// per clock when not stalled. The line memory needs no clearing after
// reset: rows 0 and 1 of every frame fill each entry before a result uses it.
// Writing image_width or image_height restarts the frame at row 0, column 0.
`default_nettype none

module unsharp_mask_3x3_rgb (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  // sharpened output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // out_row, out_col, red_out, green_out,
                                           // blue_out, zero pad
  output logic             m_axis_tlast    // frame_done
);

  localparam int MEM_W = 2 * usm3_pkg::PIX_W;

  // configuration registers
  logic [usm3_pkg::WIDTH_W-1:0]  image_width;
  logic [usm3_pkg::HEIGHT_W-1:0] image_height;
  logic [usm3_pkg::GAIN_W-1:0]   detail_gain;
  logic                          cfg_wr;
  logic [usm3_pkg::REG_IDX_W-1:0] cfg_idx;

  // frame position
  logic [usm3_pkg::COL_W-1:0]    col_pos;
  logic [usm3_pkg::ROW_W-1:0]    row_pos;
  logic [usm3_pkg::WIDTH_W-1:0]  w_eff;
  logic [usm3_pkg::HEIGHT_W-1:0] h_eff;
  logic                          col_wrap;
  logic                          row_wrap;

  // handshake and stage control
  logic accept;
  logic go_out;
  logic en3;
  logic en2;
  logic en1;
  logic s1_go;
  logic v1;
  logic v2;
  logic v3;
  logic out_valid;

  // line memory: upper half two rows above, lower half one row above
  logic [MEM_W-1:0]              line_mem [usm3_pkg::MAX_WIDTH];
  logic [MEM_W-1:0]              rd_data;

  // stage 1 payload
  logic [usm3_pkg::PIX_W-1:0]    pix1;
  logic [usm3_pkg::COL_W-1:0]    col1;
  logic [usm3_pkg::ROW_W-1:0]    row1;
  logic                          res1;
  logic                          last1;
  logic [usm3_pkg::PIX_W-1:0]    top;
  logic [usm3_pkg::PIX_W-1:0]    mid;

  // window columns c-2 and c-1, top to bottom
  logic [usm3_pkg::PIX_W-1:0]    win_c2 [3];
  logic [usm3_pkg::PIX_W-1:0]    win_c1 [3];
  logic [usm3_pkg::PIX_W-1:0]    win [9];

  // result tags through the later stages
  logic [usm3_pkg::ROW_W-1:0]    row2;
  logic [usm3_pkg::COL_W-1:0]    col2;
  logic                          last2;
  logic [usm3_pkg::ROW_W-1:0]    row3;
  logic [usm3_pkg::COL_W-1:0]    col3;
  logic                          last3;
  logic [usm3_pkg::ROW_W-1:0]    row_o;
  logic [usm3_pkg::COL_W-1:0]    col_o;
  logic                          last_o;

  usm3_pkg::chan_ctl_t           chan_ctl;
  logic [8:0][usm3_pkg::CH_W-1:0] nbr_r;
  logic [8:0][usm3_pkg::CH_W-1:0] nbr_g;
  logic [8:0][usm3_pkg::CH_W-1:0] nbr_b;
  logic [usm3_pkg::CH_W-1:0]     red_o;
  logic [usm3_pkg::CH_W-1:0]     green_o;
  logic [usm3_pkg::CH_W-1:0]     blue_o;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      usm3_pkg::REG_WIDTH:  prdata = 32'(image_width);
      usm3_pkg::REG_HEIGHT: prdata = 32'(image_height);
      usm3_pkg::REG_GAIN:   prdata = 32'(detail_gain);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 13'd480;
      detail_gain  <= 3'd2;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        usm3_pkg::REG_WIDTH:  image_width  <= pwdata[usm3_pkg::WIDTH_W-1:0];
        usm3_pkg::REG_HEIGHT: image_height <= pwdata[usm3_pkg::HEIGHT_W-1:0];
        usm3_pkg::REG_GAIN:   detail_gain  <= pwdata[usm3_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry, zero acts as one and large values clamp
  always_comb begin
    if (image_width == '0) begin
      w_eff = usm3_pkg::WIDTH_W'(1);
    end else if (image_width > usm3_pkg::WIDTH_W'(usm3_pkg::MAX_WIDTH)) begin
      w_eff = usm3_pkg::WIDTH_W'(usm3_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = usm3_pkg::HEIGHT_W'(1);
    end else if (image_height > usm3_pkg::HEIGHT_W'(usm3_pkg::MAX_HEIGHT)) begin
      h_eff = usm3_pkg::HEIGHT_W'(usm3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // stall chain from the output back to the input
  assign go_out        = !out_valid || m_axis_tready;
  assign en3           = !v3 || go_out;
  assign en2           = !v2 || en3;
  assign s1_go         = v1 && (!res1 || en2);
  assign en1           = !v1 || s1_go;
  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && en1;

  // raster position
  assign col_wrap = (usm3_pkg::WIDTH_W'(col_pos) + 12'd1) >= w_eff;
  assign row_wrap = (usm3_pkg::HEIGHT_W'(row_pos) + 13'd1) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cfg_wr && (cfg_idx == usm3_pkg::REG_WIDTH ||
                            cfg_idx == usm3_pkg::REG_HEIGHT)) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_pos + 12'd1;
      end else begin
        col_pos <= col_pos + 11'd1;
      end
    end
  end

  // line memory, read at accept and written back as the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col_pos];
    end
    if (s1_go) begin
      line_mem[col1] <= {mid, pix1};
    end
  end

  assign top = rd_data[MEM_W-1:usm3_pkg::PIX_W];
  assign mid = rd_data[usm3_pkg::PIX_W-1:0];

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1  <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
      col1  <= col_pos;
      row1  <= row_pos;
      res1  <= (row_pos >= 12'd2) && (col_pos >= 11'd2);
      last1 <= (usm3_pkg::HEIGHT_W'(row_pos) == h_eff - 13'd1) &&
               (usm3_pkg::WIDTH_W'(col_pos) == w_eff - 12'd1);
    end
  end

  // window shift as the pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_c2[0] <= win_c1[0];
      win_c2[1] <= win_c1[1];
      win_c2[2] <= win_c1[2];
      win_c1[0] <= top;
      win_c1[1] <= mid;
      win_c1[2] <= pix1;
    end
  end

  // row-major 3x3 neighborhood
  always_comb begin
    win[0] = win_c2[0]; win[1] = win_c1[0]; win[2] = top;
    win[3] = win_c2[1]; win[4] = win_c1[1]; win[5] = mid;
    win[6] = win_c2[2]; win[7] = win_c1[2]; win[8] = pix1;
    for (int k = 0; k < 9; k++) begin
      nbr_r[k] = win[k][23:16];
      nbr_g[k] = win[k][15:8];
      nbr_b[k] = win[k][7:0];
    end
  end

  // valid bits for the result stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) begin
        v2 <= s1_go && res1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (go_out) begin
        out_valid <= v3;
      end
    end
  end

  // result tags
  always_ff @(posedge clk) begin
    if (en2) begin
      row2  <= row1 - 12'd1;
      col2  <= col1 - 11'd1;
      last2 <= last1;
    end
    if (en3) begin
      row3  <= row2;
      col3  <= col2;
      last3 <= last2;
    end
    if (go_out) begin
      row_o  <= row3;
      col_o  <= col3;
      last_o <= last3;
    end
  end

  // per-channel datapaths
  assign chan_ctl.ld_sum    = en2;
  assign chan_ctl.ld_detail = en3;
  assign chan_ctl.ld_out    = go_out;

  usm3_chan u_red (
    .clk     (clk),
    .ctl     (chan_ctl),
    .nbr     (nbr_r),
    .gain    (detail_gain),
    .pix_out (red_o)
  );

  usm3_chan u_green (
    .clk     (clk),
    .ctl     (chan_ctl),
    .nbr     (nbr_g),
    .gain    (detail_gain),
    .pix_out (green_o)
  );

  usm3_chan u_blue (
    .clk     (clk),
    .ctl     (chan_ctl),
    .nbr     (nbr_b),
    .gain    (detail_gain),
    .pix_out (blue_o)
  );

  // output stream
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = last_o;
  assign m_axis_tdata  = {1'b0, blue_o, green_o, red_o, col_o, row_o};

`ifndef SYNTHESIS
  // position always inside the current geometry
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (usm3_pkg::WIDTH_W'(col_pos) < w_eff) && (usm3_pkg::HEIGHT_W'(row_pos) < h_eff))
    else $error("raster position outside frame");

  // line memory data must hold while stage 1 waits
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !s1_go |=> $stable(rd_data))
    else $error("line memory data changed under a stalled pixel");

  // frame end flag only on the last interior column
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> usm3_pkg::WIDTH_W'(col_o) == w_eff - 12'd2)
    else $error("frame end flag on wrong column");
`endif

endmodule

`default_nettype wire
